>>> rtl/pbo_pkg.sv
// package for the polyblep oscillator: constants, types and sine table function
package pbo_pkg;

   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int PHASE_BITS_DEF      = 32;

   localparam logic [21:0] F_MIN  = 22'd2560;
   localparam logic [21:0] F_MAX  = 22'd3072000;
   localparam logic [15:0] PW_MIN = 16'd3277;
   localparam logic [15:0] PW_MAX = 16'd62259;
   localparam logic [19:0] ISR_RESET = 20'd97392;
   localparam logic [15:0] PW_RESET  = 16'd32768;

   localparam logic CSR_INV_SAMPLE_RATE = 1'b0;
   localparam logic CSR_PULSE_WIDTH     = 1'b1;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // commands from controller to datapath
   typedef struct packed {
      logic load;       // capture item, compute step, advance phases
      logic div_start;  // start divider for selected correction
      logic div_sel;    // 0: main phase correction, 1: shifted phase correction
      logic finish;     // form outputs into the result register
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic div_busy;
   } sts_type;

   // quarter-wave sine in q2.14, elaboration-time style constant function
   function automatic logic [15:0] quarter_sine(input int unsigned k, input int tb);
      logic [63:0] x;
      logic [63:0] term;
      longint      sum;
      logic [63:0] r;
      x = (64'(k) * HALF_PI_Q30) >> (tb - 2);
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if ((n % 2) == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (64'(sum) * 64'd16384 + (64'd1 << 29)) >> 30;
      return r[15:0];
   endfunction

   // full sine table entry i of 2^tb
   function automatic logic signed [15:0] sine_entry(input int unsigned i, input int tb);
      int unsigned quarter;
      int unsigned q;
      int unsigned k;
      logic [15:0] v;
      quarter = (1 << tb) >> 2;
      q = i >> (tb - 2);
      k = i & (quarter - 1);
      case (q)
         0: v = quarter_sine(k, tb);
         1: v = quarter_sine(quarter - k, tb);
         2: v = -quarter_sine(k, tb);
         default: v = -quarter_sine(quarter - k, tb);
      endcase
      return signed'(v);
   endfunction

endpackage

>>> rtl/pbo_div.sv
// restoring divider: quotient of (num << 16) / den, one bit per cycle
module pbo_div #(
   parameter int PHASE_BITS = pbo_pkg::PHASE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [PHASE_BITS-1:0] num,
   input  logic [PHASE_BITS-1:0] den,
   output logic                  busy,
   output logic [16:0]           quo
);
   localparam int QB = 17;
   localparam int CW = $clog2(QB + 1);

   logic [PHASE_BITS:0]   rem_ff, rem_in;
   logic [QB-1:0]         quo_ff, quo_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic [PHASE_BITS-1:0] den_ff, den_in;
   logic [PHASE_BITS+1:0] trial;

   // num <= den here, so the quotient fits 17 bits; compare first, then shift
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      den_in  = den_ff;
      trial   = {1'b0, rem_ff} - {2'b00, den_ff};
      if (start) begin
         rem_in  = {1'b0, num};
         quo_in  = '0;
         cnt_in  = CW'(16);
         busy_in = 1'b1;
         den_in  = den;
      end else if (busy_ff) begin
         if (!trial[PHASE_BITS+1]) begin
            rem_in = {trial[PHASE_BITS-1:0], 1'b0};
            quo_in = {quo_ff[QB-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[PHASE_BITS-1:0], 1'b0};
            quo_in = {quo_ff[QB-2:0], 1'b0};
         end
         if (cnt_ff == '0) busy_in = 1'b0;
         else cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;
endmodule

>>> rtl/pbo_datapath.sv
// datapath: step, phases, polyblep corrections, waveforms and sine table
module pbo_datapath #(
   parameter int SINE_TABLE_BITS = pbo_pkg::SINE_TABLE_BITS_DEF,
   parameter int PHASE_BITS      = pbo_pkg::PHASE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  pbo_pkg::cmd_type    cmd,
   output pbo_pkg::sts_type    sts,
   input  logic [21:0]         freq_hz,
   input  logic                reset_phase,
   input  logic [19:0]         inv_sample_rate,
   input  logic [15:0]         pulse_width,
   output logic signed [15:0]  saw_out,
   output logic signed [15:0]  pulse_out,
   output logic signed [15:0]  triangle_out,
   output logic signed [15:0]  sine_out,
   output logic signed [15:0]  sub_sine_out
);
   localparam int PB = PHASE_BITS;
   localparam int TN = 1 << SINE_TABLE_BITS;

   logic [PB-1:0] main_ff, main_in, sub_ff, sub_in, dt_ff, dt_in, pw_ff, pw_in;
   logic signed [17:0] blep0_ff, blep0_in, blep1_ff, blep1_in;
   logic signed [15:0] saw_ff, pulse_ff, tri_ff, sin_ff, ssin_ff;
   logic signed [15:0] saw_in, pulse_in, tri_in, sin_in, ssin_in;

   // step from clamped frequency; pulse width clamp
   logic [21:0] f_cl;
   logic [41:0] prod;
   logic [41:0] stp;
   logic [15:0] pw_cl;
   always_comb begin
      f_cl = freq_hz;
      if (f_cl < pbo_pkg::F_MIN) f_cl = pbo_pkg::F_MIN;
      if (f_cl > pbo_pkg::F_MAX) f_cl = pbo_pkg::F_MAX;
      prod = 42'(f_cl) * 42'(inv_sample_rate);
      stp  = prod >> (40 - PB);
      pw_cl = pulse_width;
      if (pw_cl < pbo_pkg::PW_MIN) pw_cl = pbo_pkg::PW_MIN;
      if (pw_cl > pbo_pkg::PW_MAX) pw_cl = pbo_pkg::PW_MAX;
   end

   // phase advance
   logic [PB-1:0] dt_new, main_base, sub_base;
   always_comb begin
      dt_new = (stp > 42'({PB{1'b1}})) ? {PB{1'b1}} : stp[PB-1:0];
      main_base = reset_phase ? '0 : main_ff;
      sub_base  = reset_phase ? '0 : sub_ff;
      main_in = main_ff;
      sub_in  = sub_ff;
      dt_in   = dt_ff;
      pw_in   = pw_ff;
      if (cmd.load) begin
         main_in = main_base + dt_new;
         sub_in  = sub_base + (dt_new >> 1);
         dt_in   = dt_new;
         pw_in   = PB'({pw_cl, 16'd0} >> (32 - PB));
      end
   end

   // correction region select for the chosen phase
   logic [PB-1:0] t_sel, num_sel;
   logic [PB:0]   t_plus;
   logic          lo_reg, hi_reg;
   logic          sel_ff, sel_in, lo_ff, lo_in, act_ff, act_in;
   logic          div_go;
   logic          dbusy, dbusy_q_ff;
   logic [16:0]   quo;
   always_comb begin
      t_sel  = cmd.div_sel ? (main_ff - pw_ff) : main_ff;
      t_plus = {1'b0, t_sel} + {1'b0, dt_ff};
      lo_reg = t_sel < dt_ff;
      hi_reg = t_plus > {1'b1, {PB{1'b0}}};
      num_sel = lo_reg ? (dt_ff - t_sel) : t_plus[PB-1:0];
      div_go = cmd.div_start && (lo_reg || hi_reg);
      sel_in = cmd.div_start ? cmd.div_sel : sel_ff;
      lo_in  = cmd.div_start ? lo_reg : lo_ff;
      act_in = cmd.div_start ? (lo_reg || hi_reg) : act_ff;
   end

   pbo_div #(.PHASE_BITS(PB)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go),
      .num   (num_sel),
      .den   (dt_ff),
      .busy  (dbusy),
      .quo   (quo)
   );

   // square and store correction when divider finishes
   logic [33:0] wsq;
   logic signed [17:0] bval;
   always_comb begin
      wsq  = 34'(quo) * 34'(quo);
      bval = signed'(18'(wsq >> 18));
      if (lo_ff) bval = -bval;
      blep0_in = blep0_ff;
      blep1_in = blep1_ff;
      if (cmd.div_start) begin
         if (cmd.div_sel) blep1_in = '0;
         else blep0_in = '0;
      end else if (act_ff && dbusy_q_ff && !dbusy) begin
         if (sel_ff) blep1_in = bval;
         else blep0_in = bval;
      end
   end

   // sine table, filled once, read with registered data for both phases
   logic signed [15:0] sine_rom [TN];
   logic signed [15:0] sin_rd_ff, ssin_rd_ff;
   initial begin
      for (int i = 0; i < TN; i++) begin
         sine_rom[i] = pbo_pkg::sine_entry(unsigned'(i), SINE_TABLE_BITS);
      end
   end

   always_ff @(posedge clock) begin
      sin_rd_ff  <= sine_rom[main_ff[PB-1 -: SINE_TABLE_BITS]];
      ssin_rd_ff <= sine_rom[sub_ff[PB-1 -: SINE_TABLE_BITS]];
   end

   // waveform assembly
   logic signed [19:0] x, sawv, pv, av, triv;
   logic [13:0] p14;
   always_comb begin
      p14  = main_ff[PB-1 -: 14];
      x    = 20'sd2 * signed'(20'(p14)) - 20'sd16384;
      sawv = x - 20'(blep0_ff);
      pv   = ((main_ff < pw_ff) ? 20'sd16384 : -20'sd16384) + 20'(blep0_ff)
             - 20'(blep1_ff);
      av   = (x < 0) ? -x : x;
      triv = 20'sd2 * av - 20'sd16384;
      saw_in   = (sawv > 20'sd32767) ? 16'sh7fff : (sawv < -20'sd32768) ? 16'sh8000
                 : sawv[15:0];
      pulse_in = (pv > 20'sd32767) ? 16'sh7fff : (pv < -20'sd32768) ? 16'sh8000
                 : pv[15:0];
      tri_in   = (triv > 20'sd32767) ? 16'sh7fff : triv[15:0];
      sin_in   = sin_rd_ff;
      ssin_in  = ssin_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_ff    <= '0;
         sub_ff     <= '0;
         dbusy_q_ff <= 1'b0;
         act_ff     <= 1'b0;
      end else begin
         main_ff    <= main_in;
         sub_ff     <= sub_in;
         dbusy_q_ff <= dbusy;
         act_ff     <= act_in;
      end
      dt_ff    <= dt_in;
      pw_ff    <= pw_in;
      sel_ff   <= sel_in;
      lo_ff    <= lo_in;
      blep0_ff <= blep0_in;
      blep1_ff <= blep1_in;
      if (cmd.finish) begin
         saw_ff   <= saw_in;
         pulse_ff <= pulse_in;
         tri_ff   <= tri_in;
         sin_ff   <= sin_in;
         ssin_ff  <= ssin_in;
      end
   end

   assign sts.div_busy = dbusy || (act_ff && dbusy_q_ff);
   assign saw_out      = saw_ff;
   assign pulse_out    = pulse_ff;
   assign triangle_out = tri_ff;
   assign sine_out     = sin_ff;
   assign sub_sine_out = ssin_ff;
endmodule

>>> rtl/pbo_ctrl.sv
// controller: sequences load, two divisions and result handoff
module pbo_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pbo_pkg::cmd_type cmd,
   input  pbo_pkg::sts_type sts
);
   typedef enum logic [2:0] {
      S_IDLE, S_DIV0, S_WAIT0, S_DIV1, S_WAIT1, S_FIN, S_OUT
   } state_type;

   state_type state_ff;
   logic      vld_ff;
   logic      acc;

   assign req_ready = (state_ff == S_IDLE);
   assign acc       = req_valid && req_ready;

   always_comb begin
      cmd = '0;
      cmd.load = acc;
      unique case (state_ff)
         S_DIV0:  begin cmd.div_start = 1'b1; cmd.div_sel = 1'b0; end
         S_DIV1:  begin cmd.div_start = 1'b1; cmd.div_sel = 1'b1; end
         S_FIN:   cmd.finish = 1'b1;
         default: ;
      endcase
   end

   // state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE:  if (acc) state_ff <= S_DIV0;
            S_DIV0:  state_ff <= S_WAIT0;
            S_WAIT0: if (!sts.div_busy) state_ff <= S_DIV1;
            S_DIV1:  state_ff <= S_WAIT1;
            S_WAIT1: if (!sts.div_busy) state_ff <= S_FIN;
            S_FIN:   begin state_ff <= S_OUT; vld_ff <= 1'b1; end
            S_OUT:   if (rsp_ready) begin state_ff <= S_IDLE; vld_ff <= 1'b0; end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = vld_ff;

   a_vld_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == (state_ff == S_OUT)) else $error("rsp_valid out of step");
   a_no_acc_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept while result pending");
   a_fin_out: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid) else $error("finish without valid");
endmodule

>>> rtl/polyblep_oscillator_with_sub_top.sv
// top level of the polyblep oscillator with sub-octave sine
//  channel | ports                          | role
//  req     | req_valid/ready, freq_hz, reset_phase | sample tick in
//  rsp     | rsp_valid/ready, five waveforms | sample out
//  csr     | csr_we, csr_index, csr_wdata   | register write
// each of the two corrections whose phase lies within one step of an edge
// needs a division in the one shared divider, the two in turn; otherwise
// no division is started for that correction.
// reset clears the phases and sets the configuration registers to their defaults.
// a new tick is taken only after the previous result transfer.
module polyblep_oscillator_with_sub_top #(
   parameter int SINE_TABLE_BITS = pbo_pkg::SINE_TABLE_BITS_DEF,
   parameter int PHASE_BITS      = pbo_pkg::PHASE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [21:0]        req_freq_hz,
   input  logic               req_reset_phase,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_saw_out,
   output logic signed [15:0] rsp_pulse_out,
   output logic signed [15:0] rsp_triangle_out,
   output logic signed [15:0] rsp_sine_out,
   output logic signed [15:0] rsp_sub_sine_out,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [19:0]        csr_wdata
);
   logic [19:0] isr_ff;
   logic [15:0] pw_ff;
   pbo_pkg::cmd_type cmd;
   pbo_pkg::sts_type sts;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         isr_ff <= pbo_pkg::ISR_RESET;
         pw_ff  <= pbo_pkg::PW_RESET;
      end else if (csr_we) begin
         if (csr_index == pbo_pkg::CSR_INV_SAMPLE_RATE) isr_ff <= csr_wdata;
         else pw_ff <= csr_wdata[15:0];
      end
   end

   pbo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   pbo_datapath #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .PHASE_BITS      (PHASE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .freq_hz         (req_freq_hz),
      .reset_phase     (req_reset_phase),
      .inv_sample_rate (isr_ff),
      .pulse_width     (pw_ff),
      .saw_out         (rsp_saw_out),
      .pulse_out       (rsp_pulse_out),
      .triangle_out    (rsp_triangle_out),
      .sine_out        (rsp_sine_out),
      .sub_sine_out    (rsp_sub_sine_out)
   );
endmodule
